### hw/rtl/srim_pkg.sv
package srim_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_W    = 32;
    localparam int MEDIAN_W   = 33;
    localparam int HELD_W     = 11;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    // Each half of the store holds at most half of the values, rounded up.
    localparam int SIDE_DEPTH = (CAPACITY + 1) / 2;
    localparam int SIDE_CW    = $clog2(SIDE_DEPTH + 1);

    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic signed [MEDIAN_W-1:0] t_median;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [SIDE_CW-1:0]         t_side_count;

    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_REPLACE = 2'd2,
        MODE_PUSH    = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        t_value     data;
    } t_cell_ctl;

endpackage

### hw/rtl/srim_cell.sv
module srim_cell (
    input  logic               i_clk,
    input  srim_pkg::t_cell_ctl i_ctl,
    input  logic               i_descending,
    input  logic               i_occupied,
    input  srim_pkg::t_value   i_left_value,
    input  logic               i_left_ahead,
    input  srim_pkg::t_value   i_right_value,
    input  logic               i_right_ahead,
    output srim_pkg::t_value   o_value,
    output logic               o_ahead
);
    import srim_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   ordered;
    logic   ahead;

    // A cell is "ahead" when its value stays in front of the new one.
    // A push moves everything one place down, so no cell stays ahead.
    always_comb begin
        ordered = i_descending ? (r_value > i_ctl.data) : (r_value < i_ctl.data);
        ahead   = i_occupied && ordered && (i_ctl.mode != MODE_PUSH);
    end

    always_comb begin
        unique case (i_ctl.mode) inside
            MODE_HOLD: begin
                n_value = r_value;
            end
            MODE_INSERT, MODE_PUSH: begin
                if (ahead) begin
                    n_value = r_value;
                end else if (i_left_ahead) begin
                    n_value = i_ctl.data;
                end else begin
                    n_value = i_left_value;
                end
            end
            MODE_REPLACE: begin
                // The front entry leaves and the rest close up around the new value.
                if (i_right_ahead) begin
                    n_value = i_right_value;
                end else if (ahead) begin
                    n_value = i_ctl.data;
                end else begin
                    n_value = r_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_ahead = ahead;

endmodule

### hw/rtl/srim_chain.sv
module srim_chain (
    input  logic                  i_clk,
    input  srim_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_descending,
    input  srim_pkg::t_side_count i_count,
    output srim_pkg::t_value      o_front
);
    import srim_pkg::*;

    t_value value [SIDE_DEPTH];
    logic   ahead [SIDE_DEPTH];

    for (genvar i = 0; i < SIDE_DEPTH; i++) begin : g_cell
        t_value left_value;
        logic   left_ahead;
        t_value right_value;
        logic   right_ahead;

        if (i == 0) begin : g_first
            assign left_value = i_ctl.data;
            assign left_ahead = 1'b1;
        end else begin : g_inner_left
            assign left_value = value[i-1];
            assign left_ahead = ahead[i-1];
        end

        if (i == SIDE_DEPTH - 1) begin : g_last
            assign right_value = '0;
            assign right_ahead = 1'b0;
        end else begin : g_inner_right
            assign right_value = value[i+1];
            assign right_ahead = ahead[i+1];
        end

        srim_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_descending  (i_descending),
            .i_occupied    (SIDE_CW'(i) < i_count),
            .i_left_value  (left_value),
            .i_left_ahead  (left_ahead),
            .i_right_value (right_value),
            .i_right_ahead (right_ahead),
            .o_value       (value[i]),
            .o_ahead       (ahead[i])
        );
    end

    assign o_front = value[0];

endmodule

### hw/rtl/sorted_insert_running_median_unit.sv
// Running median over a stream of signed 32-bit samples. The store is split
// into two sorted chains of 512 cells: the lower half, largest value first,
// and the upper half, smallest value first, so the middle entries always sit
// at the heads of the two chains. Every cell compares its value with the
// new sample and shifts against its neighbours in parallel, so the chains
// take one sample in every clock cycle and busy stays low. Each accepted
// sample gives exactly one result, strobed by o_valid through r_pending and
// r_valid; the receiver cannot hold it off. When 1024 values are held, a
// further sample is discarded and o_dropped_full is set with the result.
module sorted_insert_running_median_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          i_sample_value,
    output logic                        o_valid,
    output logic signed [32:0]          o_median_doubled,
    output logic [10:0]                 o_values_held,
    output logic                        o_dropped_full
);
    import srim_pkg::*;

    t_count      r_count;
    t_count      n_count;
    logic        r_pending;
    logic        r_pending_drop;
    logic        r_valid;
    t_median     r_median;
    logic [HELD_W-1:0] r_held;
    logic        r_dropped;

    logic        accept;
    logic        full;
    logic        head_swap;
    t_value      lo_front;
    t_value      hi_front;
    t_side_count lo_count;
    t_side_count hi_count;
    t_cell_ctl   lo_ctl;
    t_cell_ctl   hi_ctl;
    t_median     median;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == COUNT_W'(CAPACITY));

    assign lo_count = SIDE_CW'(({1'b0, r_count} + (COUNT_W + 1)'(1)) >> 1);
    assign hi_count = SIDE_CW'(r_count >> 1);

    always_comb begin
        lo_ctl    = '{mode: MODE_HOLD, data: i_sample_value};
        hi_ctl    = '{mode: MODE_HOLD, data: i_sample_value};
        head_swap = 1'b0;
        n_count   = r_count;
        if (accept && !full) begin
            n_count = r_count + COUNT_W'(1);
            if (!r_count[0]) begin
                // The lower half grows; a sample above the upper head swaps it down.
                head_swap = (r_count != '0) && (i_sample_value > hi_front);
                if (head_swap) begin
                    lo_ctl = '{mode: MODE_PUSH, data: hi_front};
                    hi_ctl = '{mode: MODE_REPLACE, data: i_sample_value};
                end else begin
                    lo_ctl = '{mode: MODE_INSERT, data: i_sample_value};
                end
            end else begin
                head_swap = (i_sample_value < lo_front);
                if (head_swap) begin
                    hi_ctl = '{mode: MODE_PUSH, data: lo_front};
                    lo_ctl = '{mode: MODE_REPLACE, data: i_sample_value};
                end else begin
                    hi_ctl = '{mode: MODE_INSERT, data: i_sample_value};
                end
            end
        end
    end

    srim_chain u_lower (
        .i_clk        (i_clk),
        .i_ctl        (lo_ctl),
        .i_descending (1'b1),
        .i_count      (lo_count),
        .o_front      (lo_front)
    );

    srim_chain u_upper (
        .i_clk        (i_clk),
        .i_ctl        (hi_ctl),
        .i_descending (1'b0),
        .i_count      (hi_count),
        .o_front      (hi_front)
    );

    always_comb begin
        if (r_count[0]) begin
            median = {lo_front, 1'b0};
        end else begin
            median = MEDIAN_W'(lo_front) + MEDIAN_W'(hi_front);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pending <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_pending <= accept;
            r_valid   <= r_pending;
        end
    end

    // The chains settle at the transfer edge; the result is registered in the cycle after.
    always_ff @(posedge i_clk) begin
        r_pending_drop <= full;
        r_median       <= median;
        r_held         <= HELD_W'(r_count);
        r_dropped      <= r_pending_drop;
    end

    assign o_valid          = r_valid;
    assign o_median_doubled = r_median;
    assign o_values_held    = r_held;
    assign o_dropped_full   = r_dropped;

`ifndef SYNTHESIS
    a_result_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result strobe without a matching transfer");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_halves_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= COUNT_W'(2)) |-> (lo_front <= hi_front))
        else $error("lower head above upper head");

    a_drop_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped_full) |-> (o_values_held == HELD_W'(CAPACITY)))
        else $error("sample dropped while store not full");
`endif

endmodule
